[rtl/core/bmr_pkg.sv]
// Package for the banked register mode unit: payload structs, command,
// mode and exception codes, and the status word helper functions.
// No dependencies; imported by bmr_core, banked_register_mode_unit and the testbench.
package bmr_pkg;

    // Command codes carried in the command field of an input transfer.
    localparam logic [2:0] CMD_READ  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_MSR   = 3'd2;
    localparam logic [2:0] CMD_MRS   = 3'd3;
    localparam logic [2:0] CMD_POLL  = 3'd4;
    localparam logic [2:0] CMD_SWI   = 3'd5;
    localparam logic [2:0] CMD_COND  = 3'd6;

    // Processor mode numbers as reported on the result channel.
    localparam logic [2:0] MODE_USR = 3'd0;
    localparam logic [2:0] MODE_SYS = 3'd1;
    localparam logic [2:0] MODE_SVC = 3'd2;
    localparam logic [2:0] MODE_ABT = 3'd3;
    localparam logic [2:0] MODE_UND = 3'd4;
    localparam logic [2:0] MODE_IRQ = 3'd5;
    localparam logic [2:0] MODE_FIQ = 3'd6;

    // Low five status bits written on exception entry.
    localparam logic [4:0] MBITS_FIQ = 5'h11;
    localparam logic [4:0] MBITS_IRQ = 5'h12;
    localparam logic [4:0] MBITS_SVC = 5'h13;

    // Exception codes.
    localparam logic [1:0] EXC_NONE = 2'd0;
    localparam logic [1:0] EXC_FIQ  = 2'd1;
    localparam logic [1:0] EXC_IRQ  = 2'd2;
    localparam logic [1:0] EXC_SWI  = 2'd3;

    // Exception vectors.
    localparam logic [31:0] VEC_FIQ = 32'h0000_001C;
    localparam logic [31:0] VEC_IRQ = 32'h0000_0018;
    localparam logic [31:0] VEC_SWI = 32'h0000_0008;

    // Status word after reset: system mode, IRQ and FIQ masked, ARM state.
    localparam logic [31:0] STATUS_RESET = 32'h0000_00DF;

    // Byte lanes selected by the MSR field mask.
    localparam logic [31:0] LANE_CTRL = 32'h0000_00FF;
    localparam logic [31:0] LANE_EXT  = 32'h0000_FF00;
    localparam logic [31:0] LANE_STAT = 32'h00FF_0000;
    localparam logic [31:0] LANE_FLAG = 32'hFF00_0000;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  cond;
        logic [3:0]  reg_index;
        logic [31:0] write_value;
        logic        use_spsr;
        logic [3:0]  field_mask;
        logic        use_immediate;
        logic [7:0]  immediate;
        logic [3:0]  rotate;
        logic        fiq_request;
        logic        irq_request;
    } bmr_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        cond_passed;
        logic [1:0]  exception_taken;
        logic [2:0]  current_mode;
        logic        thumb_state;
        logic        access_error;
    } bmr_out_t;

    // Decode the low four status bits; unknown encodings fall back to user.
    function automatic logic [2:0] mode_of_bits(input logic [3:0] bits);
        logic [2:0] m;
        case (bits)
            4'h1:    m = MODE_FIQ;
            4'h2:    m = MODE_IRQ;
            4'h3:    m = MODE_SVC;
            4'h7:    m = MODE_ABT;
            4'hB:    m = MODE_UND;
            4'hF:    m = MODE_SYS;
            default: m = MODE_USR;
        endcase
        return m;
    endfunction

    // Evaluate a condition code against the flags {N, Z, C, V}.
    function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] flags);
        logic n;
        logic z;
        logic cf;
        logic v;
        logic r;
        n  = flags[3];
        z  = flags[2];
        cf = flags[1];
        v  = flags[0];
        case (c)
            4'h0:    r = z;
            4'h1:    r = !z;
            4'h2:    r = cf;
            4'h3:    r = !cf;
            4'h4:    r = n;
            4'h5:    r = !n;
            4'h6:    r = v;
            4'h7:    r = !v;
            4'h8:    r = cf && !z;
            4'h9:    r = !cf || z;
            4'hA:    r = (n == v);
            4'hB:    r = (n != v);
            4'hC:    r = !z && (n == v);
            4'hD:    r = z || (n != v);
            4'hE:    r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Replace the byte lanes of a word that the field mask selects.
    function automatic logic [31:0] merge_bytes(input logic [31:0] old_val,
                                                input logic [31:0] new_val,
                                                input logic [3:0]  mask);
        logic [31:0] sel;
        sel = '0;
        if (mask[0]) sel = sel | LANE_CTRL;
        if (mask[1]) sel = sel | LANE_EXT;
        if (mask[2]) sel = sel | LANE_STAT;
        if (mask[3]) sel = sel | LANE_FLAG;
        return (old_val & ~sel) | (new_val & sel);
    endfunction

endpackage

[rtl/core/bmr_core.sv]
// Register banks and status word of the banked register mode unit, with the
// single-pass command logic that reads and updates them.
// Depends on bmr_pkg.
module bmr_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  bmr_pkg::bmr_in_t  item,
    output bmr_pkg::bmr_out_t result
);
    import bmr_pkg::*;

    // Register storage: user bank R0..R15, FIQ R8..R14, and the R13, R14 and
    // saved status word of svc, abt, und and irq (indexed mode minus svc).
    logic [31:0] usr_reg      [16];
    logic [31:0] usr_next     [16];
    logic [31:0] fiq_reg      [7];
    logic [31:0] fiq_next     [7];
    logic [31:0] sp_reg       [4];
    logic [31:0] sp_next      [4];
    logic [31:0] lr_reg       [4];
    logic [31:0] lr_next      [4];
    logic [31:0] spsr_reg     [4];
    logic [31:0] spsr_next    [4];
    logic [31:0] spsr_fiq_reg;
    logic [31:0] spsr_fiq_next;
    logic [31:0] status_reg;
    logic [31:0] status_next;

    logic [2:0]  mode;
    logic        passed;
    logic        in_bank;
    logic        has_spsr;
    logic [1:0]  bank_idx;
    logic [31:0] raw_val;
    logic [31:0] read_val;
    logic [31:0] spsr_cur;
    logic [63:0] imm_dbl;
    logic [31:0] operand;
    logic        do_write;
    logic [31:0] wdata;
    logic [1:0]  exc;
    logic        err;
    logic [31:0] link;

    // Decode the current mode, the condition and the banked register view.
    always_comb begin
        mode     = mode_of_bits(status_reg[3:0]);
        passed   = cond_holds(item.cond, status_reg[31:28]);
        in_bank  = (mode >= MODE_SVC) && (mode <= MODE_IRQ);
        has_spsr = (mode != MODE_USR) && (mode != MODE_SYS);
        bank_idx = 2'(mode - MODE_SVC);
        spsr_cur = (mode == MODE_FIQ) ? spsr_fiq_reg : spsr_reg[bank_idx];
    end

    // Register read through the current bank, with the R15 offset applied.
    always_comb begin
        if (mode == MODE_FIQ && item.reg_index[3] && item.reg_index != 4'd15) begin
            raw_val = fiq_reg[item.reg_index[2:0]];
        end else if (in_bank && item.reg_index == 4'd13) begin
            raw_val = sp_reg[bank_idx];
        end else if (in_bank && item.reg_index == 4'd14) begin
            raw_val = lr_reg[bank_idx];
        end else begin
            raw_val = usr_reg[item.reg_index];
        end
        if (item.reg_index == 4'd15) begin
            if (status_reg[5]) begin
                read_val = {raw_val[31:1], 1'b0} + 32'd2;
            end else begin
                read_val = raw_val + 32'd4;
            end
        end else begin
            read_val = raw_val;
        end
    end

    // The MSR operand: the immediate rotated right by twice the rotate field,
    // or the register value.
    always_comb begin
        imm_dbl = {24'd0, item.immediate, 24'd0, item.immediate} >> {item.rotate, 1'b0};
        operand = item.use_immediate ? imm_dbl[31:0] : read_val;
    end

    // Command decode and next-state computation.
    always_comb begin
        usr_next      = usr_reg;
        fiq_next      = fiq_reg;
        sp_next       = sp_reg;
        lr_next       = lr_reg;
        spsr_next     = spsr_reg;
        spsr_fiq_next = spsr_fiq_reg;
        status_next   = status_reg;
        do_write      = 1'b0;
        wdata         = item.write_value;
        exc           = EXC_NONE;
        err           = 1'b0;
        link          = usr_reg[15] + 32'd4;

        case (item.command)
            CMD_WRITE: begin
                do_write = 1'b1;
            end
            CMD_MSR: begin
                if (passed) begin
                    if (item.use_spsr) begin
                        if (!has_spsr) begin
                            err = 1'b1;
                        end else if (mode == MODE_FIQ) begin
                            spsr_fiq_next = merge_bytes(spsr_fiq_reg, operand,
                                                        item.field_mask);
                        end else begin
                            spsr_next[bank_idx] = merge_bytes(spsr_reg[bank_idx], operand,
                                                              item.field_mask);
                        end
                    end else begin
                        status_next = merge_bytes(status_reg, operand, item.field_mask);
                    end
                end
            end
            CMD_MRS: begin
                if (passed) begin
                    if (item.use_spsr) begin
                        if (has_spsr) begin
                            do_write = 1'b1;
                            wdata    = spsr_cur;
                        end else begin
                            err = 1'b1;
                        end
                    end else begin
                        do_write = 1'b1;
                        wdata    = status_reg;
                    end
                end
            end
            CMD_POLL: begin
                // FIQ wins; taking it masks IRQ, so at most one is entered.
                if (!status_reg[6] && item.fiq_request) begin
                    exc = EXC_FIQ;
                end else if (!status_reg[7] && item.irq_request) begin
                    exc = EXC_IRQ;
                end
            end
            CMD_SWI: begin
                if (passed) begin
                    exc  = EXC_SWI;
                    link = usr_reg[15];
                end
            end
            default: begin
            end
        endcase

        // Register write through the current bank.
        if (do_write) begin
            if (mode == MODE_FIQ && item.reg_index[3] && item.reg_index != 4'd15) begin
                fiq_next[item.reg_index[2:0]] = wdata;
            end else if (in_bank && item.reg_index == 4'd13) begin
                sp_next[bank_idx] = wdata;
            end else if (in_bank && item.reg_index == 4'd14) begin
                lr_next[bank_idx] = wdata;
            end else begin
                usr_next[item.reg_index] = wdata;
            end
        end

        // Exception entry: save link and status, switch mode, load the vector.
        case (exc)
            EXC_FIQ: begin
                fiq_next[6]   = link;
                spsr_fiq_next = status_reg;
                status_next   = {status_reg[31:8], 1'b1, 1'b1, 1'b0, MBITS_FIQ};
                usr_next[15]  = VEC_FIQ;
            end
            EXC_IRQ: begin
                lr_next[2'(MODE_IRQ - MODE_SVC)]   = link;
                spsr_next[2'(MODE_IRQ - MODE_SVC)] = status_reg;
                status_next  = {status_reg[31:8], 1'b1, status_reg[6], 1'b0, MBITS_IRQ};
                usr_next[15] = VEC_IRQ;
            end
            EXC_SWI: begin
                lr_next[2'(MODE_SVC - MODE_SVC)]   = link;
                spsr_next[2'(MODE_SVC - MODE_SVC)] = status_reg;
                status_next  = {status_reg[31:8], 1'b1, status_reg[6], 1'b0, MBITS_SVC};
                usr_next[15] = VEC_SWI;
            end
            default: begin
            end
        endcase
    end

    // Result of the command: mode and Thumb state from the state after the update, read data before it.
    always_comb begin
        result.read_data       = (item.command == CMD_READ) ? read_val : 32'd0;
        result.cond_passed     = passed;
        result.exception_taken = exc;
        result.current_mode    = mode_of_bits(status_next[3:0]);
        result.thumb_state     = status_next[5];
        result.access_error    = err;
    end

    // State update, one command per fire.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 16; i++) begin
                usr_reg[i] <= '0;
            end
            for (int i = 0; i < 7; i++) begin
                fiq_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                sp_reg[i]   <= '0;
                lr_reg[i]   <= '0;
                spsr_reg[i] <= '0;
            end
            spsr_fiq_reg <= '0;
            status_reg   <= STATUS_RESET;
        end else if (fire) begin
            usr_reg      <= usr_next;
            fiq_reg      <= fiq_next;
            sp_reg       <= sp_next;
            lr_reg       <= lr_next;
            spsr_reg     <= spsr_next;
            spsr_fiq_reg <= spsr_fiq_next;
            status_reg   <= status_next;
        end
    end

endmodule

[rtl/core/banked_register_mode_unit.sv]
// A transfer loads the command register; once the result register is free or drained,
// the command runs and its result is registered, raising m_valid. One command per
// cycle unless m_ready stalls; each reads and updates the registers and status word in one pass.
// Reset (aresetn low, synchronous) zeroes all banked registers, sets the status word
// to system mode with IRQ and FIQ masked in ARM state, and empties both stages.
// Top level of the banked register mode unit; depends on bmr_pkg and bmr_core.
module banked_register_mode_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  bmr_pkg::bmr_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output bmr_pkg::bmr_out_t m_data
);
    import bmr_pkg::*;

    logic     in_valid_reg;
    logic     in_valid_next;
    bmr_in_t  in_data_reg;
    logic     out_valid_reg;
    logic     out_valid_next;
    bmr_out_t out_data_reg;
    bmr_out_t core_result;
    logic     advance;
    logic     fire;

    // The command stage moves on whenever the result register is free or drained.
    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    bmr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_data_reg),
        .result  (core_result)
    );

    // Stage valids under reset; payload registers load on a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            out_data_reg <= core_result;
        end
    end

endmodule

[tb/tb_banked_register_mode_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for banked_register_mode_unit: directed and random commands,
// an in-bench predictor of registers and status word, random stalls on both channels.
// Depends on bmr_pkg and the banked_register_mode_unit RTL.
module tb_banked_register_mode_unit;
    import bmr_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1925;
    localparam int unsigned QUIET_ITEMS    = 150;
    localparam int unsigned HOLDOFF_AFTER  = 400;
    localparam int unsigned HOLDOFF_CYCLES = 150;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int          IN_BITS        = $bits(bmr_in_t);

    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [3:0] COND_EQ = 4'h0;
    localparam logic [3:0] COND_AL = 4'hE;
    localparam logic [3:0] COND_NV = 4'hF;
    localparam int PSR_T = 5;
    localparam int PSR_F = 6;
    localparam int PSR_I = 7;
    localparam int PC_INDEX = 15;
    localparam int LR_INDEX = 14;

    // Low status bits of every defined mode, used to steer random MSR writes.
    localparam logic [3:0] MODE_CODES [7] = '{4'h0, 4'hF, 4'h3, 4'h7, 4'hB, 4'h2, 4'h1};

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    bmr_in_t   s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    bmr_out_t  m_data;

    banked_register_mode_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicted architectural state: 36 physical registers and the status word.
    logic [31:0] bank_regs [36];
    logic [31:0] status_psr;

    bmr_in_t     pending_items [$];
    bmr_out_t    expected_results [$];
    bmr_out_t    oldest_result;
    int unsigned mismatch_count = 0;

    int unsigned items_accepted = 0;
    int unsigned send_gap = 0;
    int unsigned send_gap_pct = 10;
    logic        quiet_tail = 1'b0;

    int unsigned results_taken = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pct = 10;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    int unsigned idle_cycles = 0;

    // Free-running clock.
    initial begin
        forever #1 aclk = ~aclk;
    end

    // Mode number from the low four status bits; unknown encodings act as user.
    function automatic logic [2:0] decode_mode(input logic [3:0] bits);
        unique case (bits)
            4'hF:    return MODE_SYS;
            4'h3:    return MODE_SVC;
            4'h7:    return MODE_ABT;
            4'hB:    return MODE_UND;
            4'h2:    return MODE_IRQ;
            4'h1:    return MODE_FIQ;
            default: return MODE_USR;
        endcase
    endfunction

    // First physical slot of the R13/R14/SPSR group of an exception mode.
    function automatic int group_base(input logic [2:0] mode);
        case (mode)
            MODE_SVC: return 16;
            MODE_ABT: return 19;
            MODE_UND: return 22;
            MODE_IRQ: return 25;
            default:  return 0;
        endcase
    endfunction

    function automatic int phys_index(input logic [2:0] mode, input logic [3:0] r);
        if (mode == MODE_FIQ && r >= 8 && r <= 14) begin
            return 28 + int'(r) - 8;
        end
        if (mode inside {MODE_SVC, MODE_ABT, MODE_UND, MODE_IRQ} && r >= 13 && r <= 14) begin
            return group_base(mode) + int'(r) - 13;
        end
        return int'(r);
    endfunction

    function automatic int saved_index(input logic [2:0] mode);
        if (mode == MODE_FIQ) begin
            return 35;
        end
        return group_base(mode) + 2;
    endfunction

    // Register as an instruction sees it; R15 reads ahead of the stored PC.
    function automatic logic [31:0] visible_reg(input logic [2:0] mode, input logic [3:0] r);
        logic [31:0] v;
        v = bank_regs[phys_index(mode, r)];
        if (r == 4'(PC_INDEX)) begin
            v = status_psr[PSR_T] ? {v[31:1], 1'b0} + 32'd2 : v + 32'd4;
        end
        return v;
    endfunction

    function automatic logic flags_pass(input logic [3:0] c);
        logic n;
        logic z;
        logic cy;
        logic ov;
        {n, z, cy, ov} = status_psr[31:28];
        case (c)
            4'h0: return z;
            4'h1: return !z;
            4'h2: return cy;
            4'h3: return !cy;
            4'h4: return n;
            4'h5: return !n;
            4'h6: return ov;
            4'h7: return !ov;
            4'h8: return cy && !z;
            4'h9: return !cy || z;
            4'hA: return n == ov;
            4'hB: return n != ov;
            4'hC: return !z && (n == ov);
            4'hD: return z || (n != ov);
            COND_AL: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] old_word,
                                               input logic [31:0] new_word,
                                               input logic [3:0]  lanes);
        logic [31:0] sel;
        sel = {{8{lanes[3]}}, {8{lanes[2]}}, {8{lanes[1]}}, {8{lanes[0]}}};
        return (old_word & ~sel) | (new_word & sel);
    endfunction

    // Exception entry: save link and status, switch mode, ARM state, mask interrupts.
    function automatic void enter_exception(input logic [2:0] mode, input logic [4:0] mbits,
                                            input logic [31:0] link, input logic [31:0] vector,
                                            input logic mask_fiq);
        bank_regs[phys_index(mode, 4'(LR_INDEX))] = link;
        bank_regs[saved_index(mode)] = status_psr;
        status_psr[4:0] = mbits;
        status_psr[PSR_T] = 1'b0;
        status_psr[PSR_I] = 1'b1;
        if (mask_fiq) begin
            status_psr[PSR_F] = 1'b1;
        end
        bank_regs[PC_INDEX] = vector;
    endfunction

    // Applies one command to the predicted state and returns the result it yields.
    function automatic bmr_out_t predict_result(input bmr_in_t it);
        bmr_out_t    res;
        logic [2:0]  mode;
        logic        passed;
        logic [31:0] operand;
        logic [63:0] doubled;
        logic        banked_ok;
        res = '0;
        mode = decode_mode(status_psr[3:0]);
        passed = flags_pass(it.cond);
        banked_ok = (mode != MODE_USR) && (mode != MODE_SYS);
        case (it.command)
            CMD_READ: begin
                res.read_data = visible_reg(mode, it.reg_index);
            end
            CMD_WRITE: begin
                bank_regs[phys_index(mode, it.reg_index)] = it.write_value;
            end
            CMD_MSR: begin
                if (passed) begin
                    doubled = {24'd0, it.immediate, 24'd0, it.immediate};
                    doubled = doubled >> (2 * int'(it.rotate));
                    operand = it.use_immediate ? doubled[31:0]
                                               : visible_reg(mode, it.reg_index);
                    if (!it.use_spsr) begin
                        status_psr = lane_merge(status_psr, operand, it.field_mask);
                    end else if (banked_ok) begin
                        bank_regs[saved_index(mode)] =
                            lane_merge(bank_regs[saved_index(mode)], operand, it.field_mask);
                    end else begin
                        res.access_error = 1'b1;
                    end
                end
            end
            CMD_MRS: begin
                if (passed) begin
                    if (!it.use_spsr) begin
                        bank_regs[phys_index(mode, it.reg_index)] = status_psr;
                    end else if (banked_ok) begin
                        bank_regs[phys_index(mode, it.reg_index)] = bank_regs[saved_index(mode)];
                    end else begin
                        res.access_error = 1'b1;
                    end
                end
            end
            CMD_POLL: begin
                // FIQ wins; its entry masks IRQ so both cannot be taken.
                if (!status_psr[PSR_F] && it.fiq_request) begin
                    enter_exception(MODE_FIQ, MBITS_FIQ, bank_regs[PC_INDEX] + 32'd4,
                                    VEC_FIQ, 1'b1);
                    res.exception_taken = EXC_FIQ;
                end
                if (!status_psr[PSR_I] && it.irq_request) begin
                    enter_exception(MODE_IRQ, MBITS_IRQ, bank_regs[PC_INDEX] + 32'd4,
                                    VEC_IRQ, 1'b0);
                    res.exception_taken = EXC_IRQ;
                end
            end
            CMD_SWI: begin
                if (passed) begin
                    enter_exception(MODE_SVC, MBITS_SVC, bank_regs[PC_INDEX], VEC_SWI, 1'b0);
                    res.exception_taken = EXC_SWI;
                end
            end
            default: begin
            end
        endcase
        res.cond_passed = passed;
        res.current_mode = decode_mode(status_psr[3:0]);
        res.thumb_state = status_psr[PSR_T];
        return res;
    endfunction

    function automatic bmr_in_t make_cmd(input logic [2:0] cmd, input logic [3:0] cond,
                                         input logic [3:0] ri, input logic [31:0] wval,
                                         input logic spsr, input logic [3:0] mask,
                                         input logic use_imm, input logic [7:0] imm,
                                         input logic [3:0] rot, input logic fiq,
                                         input logic irq);
        bmr_in_t it;
        it.command = cmd;
        it.cond = cond;
        it.reg_index = ri;
        it.write_value = wval;
        it.use_spsr = spsr;
        it.field_mask = mask;
        it.use_immediate = use_imm;
        it.immediate = imm;
        it.rotate = rot;
        it.fiq_request = fiq;
        it.irq_request = irq;
        return it;
    endfunction

    // Random command, weighted so that gated commands mostly pass and MSR often
    // lands on a defined mode with random interrupt masks and Thumb bit.
    function automatic bmr_in_t random_cmd();
        bmr_in_t     it;
        int unsigned pick;
        it = bmr_in_t'(IN_BITS'({$urandom, $urandom}));
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            it.command = CMD_READ;
        end else if (pick < 32) begin
            it.command = CMD_WRITE;
        end else if (pick < 54) begin
            it.command = CMD_MSR;
        end else if (pick < 66) begin
            it.command = CMD_MRS;
        end else if (pick < 80) begin
            it.command = CMD_POLL;
        end else if (pick < 88) begin
            it.command = CMD_SWI;
        end else if (pick < 98) begin
            it.command = CMD_COND;
        end else begin
            it.command = CMD_UNUSED;
        end
        if (it.command != CMD_COND && $urandom_range(0, 99) < 60) begin
            it.cond = COND_AL;
        end
        if ($urandom_range(0, 9) == 0) begin
            it.write_value = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        if (it.command == CMD_MSR && !it.use_spsr && $urandom_range(0, 1)) begin
            it.use_immediate = 1'b1;
            it.rotate = 4'h0;
            it.immediate = {3'($urandom_range(0, 7)), 1'b1, MODE_CODES[$urandom_range(0, 6)]};
            it.field_mask[0] = 1'b1;
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Driver: offers queued commands, predicts each accepted transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_result(s_data));
                items_accepted <= items_accepted + 1;
                if ((items_accepted + 1) % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       send_gap_pct <= 0;
                        1:       send_gap_pct <= 10;
                        default: send_gap_pct <= 40;
                    endcase
                end
            end
            quiet_tail <= (pending_items.size() <= QUIET_ITEMS);
            if (s_valid && !s_ready) begin
                // Hold the offered transfer until it is taken.
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                if (!quiet_tail && hold_left == 0 && $urandom_range(0, 99) < send_gap_pct) begin
                    send_gap <= $urandom_range(0, 13);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data <= pending_items.pop_front();
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall bursts plus one long hold-off to back up the pipeline.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_taken <= results_taken + 1;
                if ((results_taken + 1) % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       stall_pct <= 0;
                        1:       stall_pct <= 10;
                        default: stall_pct <= 40;
                    endcase
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_ready <= 1'b0;
            end else if (!hold_done && results_taken >= HOLDOFF_AFTER) begin
                hold_left <= HOLDOFF_CYCLES - 1;
                hold_done <= 1'b1;
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_left <= $urandom_range(0, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Monitor: each result transfer is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result read_data", m_data.read_data, 32'h0);
            end else begin
                oldest_result = expected_results.pop_front();
                if (m_data.read_data !== oldest_result.read_data) begin
                    report_mismatch("read_data", m_data.read_data, oldest_result.read_data);
                end
                if (m_data.cond_passed !== oldest_result.cond_passed) begin
                    report_mismatch("cond_passed", 32'(m_data.cond_passed),
                                    32'(oldest_result.cond_passed));
                end
                if (m_data.exception_taken !== oldest_result.exception_taken) begin
                    report_mismatch("exception_taken", 32'(m_data.exception_taken),
                                    32'(oldest_result.exception_taken));
                end
                if (m_data.current_mode !== oldest_result.current_mode) begin
                    report_mismatch("current_mode", 32'(m_data.current_mode),
                                    32'(oldest_result.current_mode));
                end
                if (m_data.thumb_state !== oldest_result.thumb_state) begin
                    report_mismatch("thumb_state", 32'(m_data.thumb_state),
                                    32'(oldest_result.thumb_state));
                end
                if (m_data.access_error !== oldest_result.access_error) begin
                    report_mismatch("access_error", 32'(m_data.access_error),
                                    32'(oldest_result.access_error));
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired with %0d results outstanding",
                         $time, expected_results.size());
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        for (int i = 0; i < 36; i++) begin
            bank_regs[i] = '0;
        end
        status_psr = STATUS_RESET;

        // R15 read and raw writes in system mode, ARM state.
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd15, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_WRITE, COND_AL, 4'd0, 32'hFFFF_FFFF, 0, 4'h0, 0, 8'h0,
                                         4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_WRITE, COND_AL, 4'd15, 32'h0000_0003, 0, 4'h0, 0, 8'h0,
                                         4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd15, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Saved status word has no meaning in system mode.
        pending_items.push_back(make_cmd(CMD_MRS, COND_AL, 4'd3, '0, 1, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd0, '0, 1, 4'hF, 1, 8'hFF, 4'h1, 0, 0));
        // Set all four flags through a rotated immediate, then test conditions.
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd0, '0, 0, 4'h8, 1, 8'hF0, 4'h4, 0, 0));
        pending_items.push_back(make_cmd(CMD_COND, COND_NV, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_COND, COND_EQ, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Enter supervisor mode in Thumb state with interrupts open, from a register.
        pending_items.push_back(make_cmd(CMD_WRITE, COND_AL, 4'd1, 32'h0000_0033, 0, 4'h0, 0, 8'h0,
                                         4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd1, '0, 0, 4'h1, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd15, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // MSR sourced from R15, then copy the saved status word back out.
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd15, '0, 1, 4'hF, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_MRS, COND_AL, 4'd2, '0, 1, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd2, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Both interrupts pending: only the fast one is taken.
        pending_items.push_back(make_cmd(CMD_POLL, COND_AL, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 1, 1));
        pending_items.push_back(make_cmd(CMD_WRITE, COND_AL, 4'd8, 32'h8000_0000, 0, 4'h0, 0, 8'h0,
                                         4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd8, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Undefined mode bits behave as user mode; unrotated immediate.
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd0, '0, 0, 4'h1, 1, 8'h14, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_READ, COND_AL, 4'd8, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Software interrupt skipped on a failed condition, taken on always.
        pending_items.push_back(make_cmd(CMD_SWI, COND_NV, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_SWI, COND_AL, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        pending_items.push_back(make_cmd(CMD_UNUSED, COND_AL, 4'd0, '0, 0, 4'h0, 0, 8'h0, 4'h0, 0, 0));
        // Empty field mask leaves the status word alone.
        pending_items.push_back(make_cmd(CMD_MSR, COND_AL, 4'd0, '0, 0, 4'h0, 1, 8'hFF, 4'hF, 0, 0));

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
            pending_items.push_back(random_cmd());
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
